/* hw/rtl/lsp_pkg.sv */
`default_nettype none

package lsp_pkg;

    // Fixed field widths
    localparam int OP_BITS       = 2;
    localparam int ADDR_BITS     = 16;
    localparam int LEN_BITS      = 17;
    localparam int STEP_BITS     = 24;
    localparam int CFG_IDX_BITS  = 2;
    localparam int CFG_DATA_BITS = 24;

    // Operation codes
    localparam logic [OP_BITS-1:0] OP_WRITE_A = 2'd0;
    localparam logic [OP_BITS-1:0] OP_WRITE_B = 2'd1;
    localparam logic [OP_BITS-1:0] OP_TICK    = 2'd2;

    // Register indexes
    localparam logic [CFG_IDX_BITS-1:0] CFG_LENGTH_A = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_LENGTH_B = 2'd1;
    localparam logic [CFG_IDX_BITS-1:0] CFG_STEP_A   = 2'd2;
    localparam logic [CFG_IDX_BITS-1:0] CFG_STEP_B   = 2'd3;

    // Step reset value: 1.0 in Q8.16
    localparam logic [STEP_BITS-1:0] STEP_UNITY = 24'h010000;

    // Per-stage control travelling with a tick
    typedef struct packed {
        logic valid;
        logic silent;
        logic use_b;
    } lsp_ctl_t;

endpackage

`default_nettype wire

/* hw/rtl/lsp_in_if.sv */
`default_nettype none

interface lsp_in_if
    import lsp_pkg::*;
#(
    parameter int SAMPLE_BITS = 16
);
    logic                          valid;
    logic                          ready;
    logic [OP_BITS-1:0]            operation;
    logic [ADDR_BITS-1:0]          address;
    logic signed [SAMPLE_BITS-1:0] sample_in;
    logic                          playing;
    logic                          use_b;

    modport source (output valid, output operation, output address, output sample_in,
                    output playing, output use_b, input ready);
    modport sink   (input valid, input operation, input address, input sample_in,
                    input playing, input use_b, output ready);
endinterface

`default_nettype wire

/* hw/rtl/lsp_out_if.sv */
`default_nettype none

interface lsp_out_if #(
    parameter int SAMPLE_BITS = 16
);
    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] sample_out;
    logic [SAMPLE_BITS-1:0]        peak;

    modport source (output valid, output sample_out, output peak, input ready);
    modport sink   (input valid, input sample_out, input peak, output ready);
endinterface

`default_nettype wire

/* hw/rtl/lsp_ram.sv */
`default_nettype none

// One write port, two registered read ports; read data holds while rd_en is low.
module lsp_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 65536
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr0,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr1,
    output logic      [WIDTH-1:0]         rd_data0,
    output logic      [WIDTH-1:0]         rd_data1
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data0 <= mem[rd_addr0];
            rd_data1 <= mem[rd_addr1];
        end
    end
endmodule

`default_nettype wire

/* hw/rtl/lsp_pos.sv */
`default_nettype none

// Read position: wrap into [0, len), split into index pair and fraction, advance.
module lsp_pos
    import lsp_pkg::*;
#(
    parameter int BUFFER_DEPTH = 65536,
    parameter int FRAC_BITS    = 16
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            advance,
    input  wire logic [$clog2(BUFFER_DEPTH):0]   len,
    input  wire logic [STEP_BITS-1:0]            step,
    output logic      [$clog2(BUFFER_DEPTH)-1:0] idx0,
    output logic      [$clog2(BUFFER_DEPTH)-1:0] idx1,
    output logic      [FRAC_BITS-1:0]            frac
);
    localparam int AW    = $clog2(BUFFER_DEPTH);
    localparam int POS_W = ((AW + FRAC_BITS > STEP_BITS) ? AW + FRAC_BITS : STEP_BITS) + 1;

    logic [POS_W-1:0] pos_reg;
    logic [POS_W-1:0] pos_next;
    logic [POS_W-1:0] lim;
    logic [POS_W-1:0] pos1;
    logic [POS_W-1:0] pos2;
    logic [AW:0]      inc;

    always_comb
    begin
        lim  = POS_W'(len) << FRAC_BITS;
        pos1 = (pos_reg >= lim) ? pos_reg - lim : pos_reg;
        // still out of range after one pass: restart at index 0, keep fraction
        pos2 = (pos1 >= lim) ? POS_W'(pos1[FRAC_BITS-1:0]) : pos1;
        idx0 = pos2[FRAC_BITS +: AW];
        frac = pos2[FRAC_BITS-1:0];
        inc  = {1'b0, idx0} + (AW+1)'(1);
        idx1 = (inc < len) ? inc[AW-1:0] : '0;
        pos_next = advance ? pos2 + POS_W'(step) : pos_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg <= '0;
        end
        else
        begin
            pos_reg <= pos_next;
        end
    end
endmodule

`default_nettype wire

/* hw/rtl/lsp_interp.sv */
`default_nettype none

// Stages after the RAM read: multiply, round and add, peak hold, output register.
module lsp_interp
    import lsp_pkg::*;
#(
    parameter int SAMPLE_BITS = 16,
    parameter int FRAC_BITS   = 16
) (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire lsp_ctl_t               ctl_in,
    input  wire logic [FRAC_BITS-1:0]   frac_in,
    output logic                        take,
    input  wire logic [SAMPLE_BITS-1:0] rd_a0,
    input  wire logic [SAMPLE_BITS-1:0] rd_a1,
    input  wire logic [SAMPLE_BITS-1:0] rd_b0,
    input  wire logic [SAMPLE_BITS-1:0] rd_b1,
    lsp_out_if.source                   dst
);
    localparam int PROD_W = SAMPLE_BITS + FRAC_BITS + 2;
    localparam int SUM_W  = SAMPLE_BITS + 2;
    localparam logic signed [PROD_W-1:0] HALF = PROD_W'(1) << (FRAC_BITS - 1);

    lsp_ctl_t                       ctl1_reg, ctl2_reg;
    logic [FRAC_BITS-1:0]           frac1_reg;
    logic signed [PROD_W-1:0]       prod2_reg;
    logic signed [SAMPLE_BITS-1:0]  s02_reg;
    logic                           out_valid_reg;
    logic signed [SAMPLE_BITS-1:0]  sample_reg;
    logic [SAMPLE_BITS-1:0]         peak_reg;

    logic                           out_free, p2_free;
    logic signed [SAMPLE_BITS-1:0]  s0, s1;
    logic signed [SAMPLE_BITS:0]    diff;
    logic signed [FRAC_BITS:0]      frac_s;
    logic signed [PROD_W-1:0]       prod_c;
    logic signed [PROD_W-1:0]       rounded;
    logic signed [SUM_W-1:0]        sum;
    logic signed [SAMPLE_BITS-1:0]  sample_c;
    logic [SAMPLE_BITS-1:0]         mag;

    assign out_free = !out_valid_reg || dst.ready;
    assign p2_free  = !ctl2_reg.valid || out_free;
    assign take     = !ctl1_reg.valid || p2_free;

    always_comb
    begin
        s0      = ctl1_reg.use_b ? rd_b0 : rd_a0;
        s1      = ctl1_reg.use_b ? rd_b1 : rd_a1;
        diff    = (SAMPLE_BITS+1)'(s1) - (SAMPLE_BITS+1)'(s0);
        frac_s  = {1'b0, frac1_reg};
        prod_c  = PROD_W'(diff) * PROD_W'(frac_s);

        // round half up, then step back to sample scale
        rounded = (prod2_reg + HALF) >>> FRAC_BITS;
        sum     = SUM_W'(s02_reg) + rounded[SUM_W-1:0];
        sample_c = ctl2_reg.silent ? '0 : sum[SAMPLE_BITS-1:0];
        mag     = sample_c[SAMPLE_BITS-1] ? (~sample_c + SAMPLE_BITS'(1)) : sample_c;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl1_reg      <= '0;
            ctl2_reg      <= '0;
            out_valid_reg <= 1'b0;
            peak_reg      <= '0;
        end
        else
        begin
            if (take)
            begin
                ctl1_reg <= ctl_in;
            end
            if (p2_free)
            begin
                ctl2_reg <= ctl1_reg;
            end
            if (out_free)
            begin
                out_valid_reg <= ctl2_reg.valid;
                if (ctl2_reg.valid && (mag > peak_reg))
                begin
                    peak_reg <= mag;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            frac1_reg <= frac_in;
        end
        if (p2_free)
        begin
            prod2_reg <= prod_c;
            s02_reg   <= s0;
        end
        if (out_free)
        begin
            sample_reg <= sample_c;
        end
    end

    assign dst.valid      = out_valid_reg;
    assign dst.sample_out = sample_reg;
    assign dst.peak       = peak_reg;
endmodule

`default_nettype wire

/* hw/rtl/looping_interp_sample_player.sv */
// Looping sample player with linear interpolation.
//
// in_ch carries one transaction per operation: a write into buffer A or B
// (address, sample_in), or a tick (playing, use_b). Writes give no result;
// every tick gives one out_ch transaction with sample_out and the running peak.
// The cfg port (cfg_wr_en, cfg_index, cfg_data) sets buffer lengths and Q8.16
// steps; write it only while no tick is in flight.
//
// Throughput: one transaction per clock while out_ch is not stalled. The position
// accumulator wraps and advances in the accepting cycle, so ticks follow each
// other back to back. A tick's result is registered after the RAM read,
// multiply and round/add stages.
// When out_ch stalls, up to three ticks sit in the pipe and in_ch keeps
// accepting until the stages behind the output register are full.
// Reset clears position, peak, lengths (0) and steps (1.0); buffer contents
// are not cleared and need no clearing pass.
`default_nettype none

module looping_interp_sample_player
    import lsp_pkg::*;
#(
    parameter int BUFFER_DEPTH = 65536,
    parameter int SAMPLE_BITS  = 16,
    parameter int FRAC_BITS    = 16
) (
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    lsp_in_if.sink                        in_ch,
    lsp_out_if.source                     out_ch,
    input  wire logic                     cfg_wr_en,
    input  wire logic [CFG_IDX_BITS-1:0]  cfg_index,
    input  wire logic [CFG_DATA_BITS-1:0] cfg_data
);
    localparam int AW    = $clog2(BUFFER_DEPTH);
    localparam int WA_W  = ((AW > ADDR_BITS) ? AW : ADDR_BITS) + 1;  // room for DEPTH
    localparam int CMP_W = (LEN_BITS > AW + 1) ? LEN_BITS : AW + 1;

    // Configuration registers
    logic [LEN_BITS-1:0]  length_a_reg, length_b_reg;
    logic [STEP_BITS-1:0] step_a_reg, step_b_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            length_a_reg <= '0;
            length_b_reg <= '0;
            step_a_reg   <= STEP_UNITY;
            step_b_reg   <= STEP_UNITY;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_index)
                CFG_LENGTH_A: length_a_reg <= cfg_data[LEN_BITS-1:0];
                CFG_LENGTH_B: length_b_reg <= cfg_data[LEN_BITS-1:0];
                CFG_STEP_A:   step_a_reg   <= cfg_data[STEP_BITS-1:0];
                CFG_STEP_B:   step_b_reg   <= cfg_data[STEP_BITS-1:0];
                default:      ;
            endcase
        end
    end

    // Input decode
    logic            in_fire, tick_fire, addr_ok, wr_a, wr_b;
    logic [WA_W-1:0] wa_wide;
    logic [AW-1:0]   wr_addr;

    assign in_fire   = in_ch.valid && in_ch.ready;
    assign tick_fire = in_fire && (in_ch.operation == OP_TICK);
    assign wa_wide   = WA_W'(in_ch.address);
    assign addr_ok   = wa_wide < WA_W'(BUFFER_DEPTH);  // writes past the end are dropped
    assign wr_addr   = wa_wide[AW-1:0];
    assign wr_a      = in_fire && addr_ok && (in_ch.operation == OP_WRITE_A);
    assign wr_b      = in_fire && addr_ok && (in_ch.operation == OP_WRITE_B);

    // Buffer selection; lengths above the depth act as the full depth
    logic [LEN_BITS-1:0]  len_sel;
    logic [CMP_W-1:0]     len_wide, len_clamp;
    logic [AW:0]          len_c;
    logic [STEP_BITS-1:0] step_sel;
    logic                 active;

    always_comb
    begin
        len_sel   = in_ch.use_b ? length_b_reg : length_a_reg;
        step_sel  = in_ch.use_b ? step_b_reg : step_a_reg;
        len_wide  = CMP_W'(len_sel);
        len_clamp = (len_wide > CMP_W'(BUFFER_DEPTH)) ? CMP_W'(BUFFER_DEPTH) : len_wide;
        len_c     = len_clamp[AW:0];
        active    = in_ch.playing && (len_c != '0);
    end

    // Position accumulator and read addresses
    logic [AW-1:0]        idx0, idx1;
    logic [FRAC_BITS-1:0] frac;

    lsp_pos #(
        .BUFFER_DEPTH (BUFFER_DEPTH),
        .FRAC_BITS    (FRAC_BITS)
    ) u_pos (
        .clk     (clk),
        .rst_n   (rst_n),
        .advance (tick_fire && active),
        .len     (len_c),
        .step    (step_sel),
        .idx0    (idx0),
        .idx1    (idx1),
        .frac    (frac)
    );

    // Sample memories; both are read on a tick, the interp stage picks one
    logic [SAMPLE_BITS-1:0] rd_a0, rd_a1, rd_b0, rd_b1;

    lsp_ram #(
        .WIDTH (SAMPLE_BITS),
        .DEPTH (BUFFER_DEPTH)
    ) u_ram_a (
        .clk      (clk),
        .wr_en    (wr_a),
        .wr_addr  (wr_addr),
        .wr_data  (in_ch.sample_in),
        .rd_en    (tick_fire),
        .rd_addr0 (idx0),
        .rd_addr1 (idx1),
        .rd_data0 (rd_a0),
        .rd_data1 (rd_a1)
    );

    lsp_ram #(
        .WIDTH (SAMPLE_BITS),
        .DEPTH (BUFFER_DEPTH)
    ) u_ram_b (
        .clk      (clk),
        .wr_en    (wr_b),
        .wr_addr  (wr_addr),
        .wr_data  (in_ch.sample_in),
        .rd_en    (tick_fire),
        .rd_addr0 (idx0),
        .rd_addr1 (idx1),
        .rd_data0 (rd_b0),
        .rd_data1 (rd_b1)
    );

    // Interpolation pipe and output register
    lsp_ctl_t ctl_in;
    logic     take;

    assign ctl_in = '{valid: tick_fire, silent: !active, use_b: in_ch.use_b};

    lsp_interp #(
        .SAMPLE_BITS (SAMPLE_BITS),
        .FRAC_BITS   (FRAC_BITS)
    ) u_interp (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctl_in  (ctl_in),
        .frac_in (frac),
        .take    (take),
        .rd_a0   (rd_a0),
        .rd_a1   (rd_a1),
        .rd_b0   (rd_b0),
        .rd_b1   (rd_b1),
        .dst     (out_ch)
    );

    assign in_ch.ready = take;

    // Checks
    logic [SAMPLE_BITS-1:0] out_mag;

    assign out_mag = out_ch.sample_out[SAMPLE_BITS-1]
                   ? (~out_ch.sample_out + SAMPLE_BITS'(1)) : out_ch.sample_out;

    // input backs up only when the output transaction is stalled
    a_ready_low_only_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ch.ready |-> (out_ch.valid && !out_ch.ready))
        else $error("in_ch stalled without output backpressure");

    a_peak_covers_sample: assert property (@(posedge clk) disable iff (!rst_n)
        out_ch.valid |-> (out_mag <= out_ch.peak))
        else $error("peak below magnitude of presented sample");

    a_peak_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
        (out_ch.valid && out_ch.ready) |=> (!out_ch.valid || (out_ch.peak >= $past(out_ch.peak))))
        else $error("peak decreased between transactions");
endmodule

`default_nettype wire
